// File: hdl/tpc_pkg.sv
// Package for the thermal pixel calibration block.
// Holds the Q15 rounding/saturation and unsigned saturating-add helpers.
// No dependencies.
package tpc_pkg;

  localparam int unsigned TableDepthDefault = 65536;
  localparam int unsigned SampleW           = 16;

  localparam logic signed [SampleW-1:0] Q15Max = 16'sh7fff;
  localparam logic signed [SampleW-1:0] Q15Min = 16'sh8000;
  localparam logic [SampleW-1:0]        UMax   = 16'hffff;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_TABLE = 1'b1
  } req_type_t;

  // Doubling multiply-high with rounding: sat16((2*prod + 2^15) >>> 16).
  function automatic logic signed [SampleW-1:0] q15_round(
    input logic signed [2*SampleW-1:0] prod
  );
    logic signed [2*SampleW:0] p;
    logic signed [SampleW:0]   r;
    p = $signed({prod, 1'b0}) + 33'sd32768;
    r = p[2*SampleW:SampleW];
    if (r > 17'sd32767) begin
      return Q15Max;
    end else if (r < -17'sd32768) begin
      return Q15Min;
    end else begin
      return r[SampleW-1:0];
    end
  endfunction

  function automatic logic [SampleW-1:0] sat_add(
    input logic [SampleW-1:0] a,
    input logic [SampleW-1:0] b
  );
    logic [SampleW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SampleW] ? UMax : s[SampleW-1:0];
  endfunction

endpackage

// File: hdl/thermal_pixel_calibration.sv
// Thermal pixel calibration: dark subtract, gain and emissivity, offsets, table write and lookup.
// Stages: dark subtract, gain, emissivity, flag add, column add, table read to output.
// Throughput: one word per cycle; the whole pipeline stalls together while a
// result waits at the output register; the table stage does one read or write per word.
// Reset: rst (synchronous) clears stage valid bits, output valid and flag_reference;
// the temperature table is not cleared and must be written before it is read.
module thermal_pixel_calibration
  import tpc_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [15:0] raw_sample,
  input  logic [15:0] dark_level,
  input  logic signed [15:0] gain_q15,
  input  logic signed [15:0] emissivity_q15,
  input  logic [15:0] column_offset,
  input  logic [15:0] table_address,
  input  logic [15:0] table_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] temperature_code
);

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

  logic        advance;
  logic [15:0] flag_reference;

  // stage 1: dark subtract
  logic              v1;
  logic              t1;
  logic [15:0]       corr1;
  logic signed [15:0] gain1, emis1;
  logic [15:0]       coff1, addr1, data1;
  // stage 2: gain product
  logic              v2, t2;
  logic signed [31:0] prod2;
  logic signed [15:0] emis2;
  logic [15:0]       coff2, addr2, data2;
  // stage 3: gain round
  logic              v3, t3;
  logic signed [15:0] g3, emis3;
  logic [15:0]       coff3, addr3, data3;
  // stage 4: emissivity product
  logic              v4, t4;
  logic signed [31:0] prod4;
  logic [15:0]       coff4, addr4, data4;
  // stage 5: round and flag add
  logic              v5, t5;
  logic [15:0]       sum5, coff5, addr5, data5;
  // stage 6: column add, table address
  logic [15:0]       col_sum;
  logic              v6, t6;
  logic [AddrW-1:0]  addr6;
  logic [15:0]       data6;

  logic [15:0] temperature_table [TABLE_DEPTH];

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;
  assign col_sum   = sat_add(sum5, coff5);

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_reference <= '0;
    end else if (cfg_valid && cfg_ready) begin
      flag_reference <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6 && (t6 == REQ_PIXEL);
    end
  end

  // payload path, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      t1    <= req_type;
      corr1 <= (raw_sample > dark_level) ? raw_sample - dark_level : '0;
      gain1 <= gain_q15;
      emis1 <= emissivity_q15;
      coff1 <= column_offset;
      addr1 <= table_address;
      data1 <= table_data;

      t2    <= t1;
      prod2 <= $signed(corr1) * gain1;
      emis2 <= emis1;
      coff2 <= coff1;
      addr2 <= addr1;
      data2 <= data1;

      t3    <= t2;
      g3    <= q15_round(prod2);
      emis3 <= emis2;
      coff3 <= coff2;
      addr3 <= addr2;
      data3 <= data2;

      t4    <= t3;
      prod4 <= g3 * emis3;
      coff4 <= coff3;
      addr4 <= addr3;
      data4 <= data3;

      // reread the signed product as unsigned before the saturating add
      t5    <= t4;
      sum5  <= sat_add(q15_round(prod4), flag_reference);
      coff5 <= coff4;
      addr5 <= addr4;
      data5 <= data4;

      t6    <= t5;
      addr6 <= (t5 == REQ_TABLE) ? addr5[AddrW-1:0] : col_sum[AddrW-1:0];
      data6 <= data5;
    end
  end

  // table writes and reads share one stage, so they stay in word order
  always_ff @(posedge clk) begin
    if (advance && v6) begin
      if (t6 == REQ_TABLE) begin
        temperature_table[addr6] <= data6;
      end else begin
        temperature_code <= temperature_table[addr6];
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable({v1, v2, v3, v4, v5, v6}))
    else $error("pipeline valid bits moved during stall");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    (advance && v6 && t6 == REQ_TABLE) |=> !out_valid)
    else $error("table write produced a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v6 && t6 == REQ_PIXEL))
    else $error("result without a pixel word in the last stage");

  a_pixel_result: assert property (@(posedge clk) disable iff (rst)
    (advance && v6 && t6 == REQ_PIXEL) |=> out_valid)
    else $error("pixel word lost at table stage");

endmodule

// File: dv/thermal_pixel_calibration_tb.sv
// Self-checking testbench for thermal_pixel_calibration: pixel and table words,
// flag reference settings, random idling, and a long output hold-off.
// Depends on tpc_pkg and the thermal_pixel_calibration RTL.
`timescale 1ns / 1ps

module thermal_pixel_calibration_tb;
  import tpc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 12;

  class temp_code_board;
    bit [15:0] lut [0:65535];
    bit [15:0] flag_ref;
    bit [15:0] due_codes [$];
    int errors;
    int checked;
    int pixels;
    int lut_writes;

    static function logic signed [15:0] q15_dbl_mul(logic signed [15:0] a,
                                                    logic signed [15:0] b);
      longint p;
      p = (2 * longint'(a) * longint'(b) + 32768) >>> 16;
      if (p > 32767) return 16'sh7fff;
      if (p < -32768) return 16'sh8000;
      return p[15:0];
    endfunction

    function bit [15:0] lut_index(logic [15:0] raw, logic [15:0] dark,
                                  logic signed [15:0] gain, logic signed [15:0] emis,
                                  logic [15:0] coff);
      logic [15:0] corr;
      logic signed [15:0] v;
      int sum;
      corr = (raw > dark) ? raw - dark : 16'd0;
      v = q15_dbl_mul(signed'(corr), gain);
      v = q15_dbl_mul(v, emis);
      // reread the product as unsigned before the saturating adds
      sum = {16'd0, v};
      sum += flag_ref;
      if (sum > 65535) sum = 65535;
      sum += coff;
      if (sum > 65535) sum = 65535;
      return sum[15:0];
    endfunction

    function void note_word(req_type_t req, logic [15:0] raw, logic [15:0] dark,
                            logic signed [15:0] gain, logic signed [15:0] emis,
                            logic [15:0] coff, logic [15:0] addr, logic [15:0] data);
      if (req == REQ_TABLE) begin
        lut[addr] = data;
        lut_writes++;
      end else begin
        due_codes.push_back(lut[lut_index(raw, dark, gain, emis, coff)]);
        pixels++;
      end
    endfunction

    function void check_code(logic [15:0] code);
      bit [15:0] want;
      if (due_codes.size() == 0) begin
        $display("%0t: unexpected temperature_code %h, expected none", $time, code);
        errors++;
        return;
      end
      want = due_codes.pop_front();
      checked++;
      if (code !== want) begin
        $display("%0t: temperature_code mismatch, expected %h, got %h", $time, want, code);
        errors++;
      end
    endfunction

    function bit busy();
      return due_codes.size() != 0;
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_PIXEL;
  logic [15:0] raw_sample = '0;
  logic [15:0] dark_level = '0;
  logic signed [15:0] gain_q15 = '0;
  logic signed [15:0] emissivity_q15 = '0;
  logic [15:0] column_offset = '0;
  logic [15:0] table_address = '0;
  logic [15:0] table_data = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [15:0] temperature_code;

  temp_code_board board = new();
  bit     loaded [0:65535];
  int     idle_pct;
  int     stall_pct;
  int     hold_left;
  int     words_sent;
  int     settings_used;
  longint cycle_count;

  thermal_pixel_calibration u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .raw_sample(raw_sample),
    .dark_level(dark_level),
    .gain_q15(gain_q15),
    .emissivity_q15(emissivity_q15),
    .column_offset(column_offset),
    .table_address(table_address),
    .table_data(table_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .temperature_code(temperature_code)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check accepted words, then pick ready for the next edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) board.check_code(temperature_code);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_word(req_type_t req, logic [15:0] raw, logic [15:0] dark,
                           logic signed [15:0] gain, logic signed [15:0] emis,
                           logic [15:0] coff, logic [15:0] addr, logic [15:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    req_type       <= req;
    raw_sample     <= raw;
    dark_level     <= dark;
    gain_q15       <= gain;
    emissivity_q15 <= emis;
    column_offset  <= coff;
    table_address  <= addr;
    table_data     <= data;
    do @(posedge clk); while (!in_ready);
    board.note_word(req, raw, dark, gain, emis, coff, addr, data);
    words_sent++;
  endtask

  // pixel fields are don't-care on a table word; fill them with noise
  task automatic lut_word(logic [15:0] addr, logic [15:0] data);
    loaded[addr] = 1'b1;
    send_word(REQ_TABLE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), addr, data);
  endtask

  // load the selected entry first if nothing was stored there yet
  task automatic pixel_word(logic [15:0] raw, logic [15:0] dark, logic signed [15:0] gain,
                            logic signed [15:0] emis, logic [15:0] coff);
    bit [15:0] idx;
    idx = board.lut_index(raw, dark, gain, emis, coff);
    if (!loaded[idx]) lut_word(idx, 16'($urandom));
    send_word(REQ_PIXEL, raw, dark, gain, emis, coff, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_word();
    int pick;
    logic [15:0] dark;
    logic [15:0] raw;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      lut_word(16'($urandom), 16'($urandom));
    end else if (pick < 30) begin
      pixel_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
    end else begin
      // plausible sensor word: small signal over dark, gain and emissivity near one
      dark = 16'($urandom_range(0, 40000));
      if ($urandom_range(0, 9) == 0) raw = dark >> 1;
      else raw = dark + 16'($urandom_range(0, 9000));
      pixel_word(raw, dark, 16'($urandom_range(24000, 32767)),
                 16'($urandom_range(26000, 32767)), 16'($urandom_range(0, 2000)));
    end
  endtask

  // drop valid, drain all pending results, then give table words time to land
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.busy());
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_flag(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.flag_ref = value;
    settings_used++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int idle, int stall, logic [15:0] flag, int count, bit squeeze);
    int target;
    settle();
    write_flag(flag);
    idle_pct  = idle;
    stall_pct = stall;
    if (squeeze) hold_left = 400;
    target = words_sent + count;
    while (words_sent < target) random_word();
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_flag(16'h0000);
    lut_word(16'h0000, 16'hffff);
    lut_word(16'hffff, 16'h0000);
    lut_word(16'hffff, 16'h1234);
    pixel_word(16'h0000, 16'h0000, 16'sh7fff, 16'sh7fff, 16'h0000);
    // raw below dark clamps to zero
    pixel_word(16'h1000, 16'hffff, 16'sh7fff, 16'sh7fff, 16'h0000);
    pixel_word(16'hffff, 16'h0000, 16'sh7fff, 16'sh7fff, 16'h0000);
    // minus one times minus one saturates to just under one
    pixel_word(16'h8000, 16'h0000, 16'sh8000, 16'sh8000, 16'h0000);
    pixel_word(16'h8000, 16'h0000, 16'sh8000, 16'sh8000, 16'h7fff);
    pixel_word(16'h4000, 16'h0000, 16'sh7fff, 16'sh7fff, 16'hffff);
    // negative product turns into a large unsigned index
    pixel_word(16'h2000, 16'h0000, 16'shc000, 16'sh7fff, 16'h0000);
    pixel_word(16'h7fff, 16'h0000, 16'sh7fff, 16'sh8000, 16'h0010);
    pixel_word(16'h3000, 16'h1000, 16'sh0000, 16'sh8000, 16'h0123);
    pixel_word(16'hffff, 16'hfffe, 16'sh4000, 16'sh4000, 16'h0000);
    lut_word(16'h0000, 16'h5a5a);
    pixel_word(16'h0000, 16'hffff, 16'sh8000, 16'sh7fff, 16'h0000);

    run_phase(0, 0, 16'hffff, 80, 1'b0);
    run_phase(0, 0, 16'($urandom), 200, 1'b0);
    run_phase(79, 0, 16'($urandom_range(0, 4095)), 200, 1'b0);
    run_phase(0, 79, 16'h0001, 200, 1'b0);
    run_phase(30, 30, 16'($urandom), 200, 1'b0);
    run_phase(0, 0, 16'h0000, 170, 1'b1);

    settle();
    $display("Sent %0d words (%0d pixels, %0d table writes) over %0d flag settings.",
             words_sent, board.pixels, board.lut_writes, settings_used);
    $display("Checked %0d temperature codes, %0d mismatches.", board.checked, board.errors);
    if (board.errors == 0 && !board.busy()) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
